>>> src/lid_angle_peripheral_gate_defines.svh
// ----------------------------------------------------------------------------
// Lid angle peripheral gate assertion macros
// Shared property forms for the checker; clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LID_ANGLE_PERIPHERAL_GATE_DEFINES_SVH
`define LID_ANGLE_PERIPHERAL_GATE_DEFINES_SVH

// Same-cycle implication.
`define LAPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lid angle gate check failed");

// Next-cycle implication.
`define LAPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lid angle gate check failed");

`endif

>>> src/lapg_pkg.sv
// ----------------------------------------------------------------------------
// Lid angle peripheral gate package
// Request and result types, op and decision codes, band constants.
// ----------------------------------------------------------------------------
package lapg_pkg;

    localparam int WINDOW_DEPTH   = 4;
    localparam bit TABLET_SUPPORT = 1'b1;

    localparam int ANGLE_W = 9;
    localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    localparam logic [ANGLE_W-1:0] LID_LOW_DEG   = 9'd13;
    localparam logic [ANGLE_W-1:0] HYST_DEG      = 9'd2;
    localparam logic [ANGLE_W-1:0] MIN_LARGE     = 9'd0;
    localparam logic [ANGLE_W-1:0] MAX_LARGE     = 9'd360;
    localparam logic [ANGLE_W-1:0] DEFAULT_LARGE = 9'd180;
    localparam logic [ANGLE_W-1:0] ENABLE_LOW    = LID_LOW_DEG + HYST_DEG;
    localparam logic [ANGLE_W-1:0] IGNORE_HIGH   = LID_LOW_DEG - HYST_DEG;

    typedef enum logic [1:0] {
        OP_ANGLE   = 2'd0,
        OP_RESUME  = 2'd1,
        OP_SUSPEND = 2'd2,
        OP_RSVD    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REQ_NONE    = 2'd0,
        REQ_ENABLE  = 2'd1,
        REQ_DISABLE = 2'd2
    } req_t;

    typedef struct packed {
        op_t                op;
        logic [ANGLE_W-1:0] angle;
        logic               angle_reliable;
        logic               tablet_active;
        logic               chipset_on;
    } sample_t;

    typedef struct packed {
        req_t decision;
        logic keyboard_on;
        logic window_unreliable;
    } result_t;

endpackage

>>> src/lid_angle_peripheral_gate.sv
// ----------------------------------------------------------------------------
// Lid angle peripheral gate
// Windowed hysteresis qualifier that gates the keyboard scan by lid angle.
// ----------------------------------------------------------------------------
// Usage: requests enter on sample/sample_valid/sample_ready: a lid angle
// sample, a chipset resume or a chipset suspend. Every request gives exactly
// one result on result/result_valid/result_ready: the decision taken, the
// keyboard enable after it and whether the angle window holds an unreliable
// sample. The wake angle is written on cfg_valid/cfg_data (cfg_ready is
// always high); values above 360 are stored as 360. Write it only when no
// request is in flight.
// The input register takes the request, and one pass of band compares over the
// window then loads the result register. Throughput is one request per cycle
// while results are taken. If the receiver stalls, the result holds and the
// input register still takes one more request; after that sample_ready drops
// until the result is taken.
// Reset clears the window to reliable zero angles, the write slot to zero,
// the keyboard enable to on and the wake angle to 180.
// ----------------------------------------------------------------------------
module lid_angle_peripheral_gate
    import lapg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    input  sample_t             sample,
    output logic                result_valid,
    input  logic                result_ready,
    output result_t             result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ANGLE_W-1:0]  cfg_data
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

    logic               in_valid_reg;
    sample_t            in_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    result_t            out_next;
    logic [ANGLE_W-1:0] wake_reg;
    logic [ANGLE_W-1:0] wake_next;
    logic [ANGLE_W-1:0] ring_angle_reg  [WINDOW_DEPTH];
    logic [ANGLE_W-1:0] ring_angle_next [WINDOW_DEPTH];
    logic               ring_ok_reg     [WINDOW_DEPTH];
    logic               ring_ok_next    [WINDOW_DEPTH];
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic               kb_reg;
    logic               kb_next;
    logic               advance;
    logic               take_in;
    logic               force_off;
    logic               unreliable;
    logic               all_enable;
    logic               all_ignore;
    logic               req_valid;
    logic               req_enable;
    logic               final_enable;
    logic [ANGLE_W:0]   wake_lo;
    logic [ANGLE_W:0]   wake_hi;
    logic [ANGLE_W:0]   angle_up;

    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign sample_ready = !in_valid_reg || advance;
    assign take_in      = sample_valid && sample_ready;
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign wake_next = (cfg_data > MAX_LARGE) ? MAX_LARGE : cfg_data;
    assign wake_lo   = {1'b0, wake_reg};
    assign wake_hi   = {1'b0, wake_reg} + {1'b0, HYST_DEG};
    assign force_off = TABLET_SUPPORT && in_reg.tablet_active;

    // Window after this request, then the band checks over every slot.
    always_comb
    begin
        all_enable = 1'b1;
        all_ignore = 1'b1;
        unreliable = 1'b0;
        angle_up   = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++)
        begin
            if (in_reg.op == OP_ANGLE && slot_reg == SLOT_W'(i))
            begin
                ring_angle_next[i] = in_reg.angle;
                ring_ok_next[i]    = in_reg.angle_reliable;
            end
            else
            begin
                ring_angle_next[i] = ring_angle_reg[i];
                ring_ok_next[i]    = ring_ok_reg[i];
            end
            unreliable = unreliable || !ring_ok_next[i];
            angle_up   = {1'b0, ring_angle_next[i]} + {1'b0, HYST_DEG};
            if (wake_reg == MIN_LARGE)
            begin
                all_enable = 1'b0;
            end
            else if (wake_reg != MAX_LARGE)
            begin
                if (ring_angle_next[i] < ENABLE_LOW || angle_up > wake_lo)
                    all_enable = 1'b0;
                if (ring_angle_next[i] > IGNORE_HIGH && {1'b0, ring_angle_next[i]} < wake_hi)
                    all_ignore = 1'b0;
            end
            if (wake_reg == MAX_LARGE)
                all_ignore = 1'b0;
        end
    end

    always_comb
    begin
        req_valid  = 1'b0;
        req_enable = 1'b0;
        slot_next  = slot_reg;
        unique case (in_reg.op)
            OP_ANGLE:
            begin
                slot_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                if (!unreliable)
                begin
                    req_valid  = all_enable || all_ignore;
                    req_enable = all_enable;
                end
            end
            OP_RESUME:
            begin
                req_valid  = 1'b1;
                req_enable = 1'b1;
            end
            OP_SUSPEND:
            begin
                req_valid = force_off;
            end
            default:
            begin
                req_valid = 1'b0;
            end
        endcase

        final_enable = req_enable && !force_off;
        kb_next      = kb_reg;
        if (req_valid)
        begin
            if (final_enable)
                kb_next = 1'b1;
            else if (!in_reg.chipset_on)
                kb_next = 1'b0;
        end

        out_next.decision          = !req_valid ? REQ_NONE :
                                     (final_enable ? REQ_ENABLE : REQ_DISABLE);
        out_next.keyboard_on       = kb_next;
        out_next.window_unreliable = unreliable;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wake_reg      <= DEFAULT_LARGE;
            slot_reg      <= '0;
            kb_reg        <= 1'b1;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                ring_angle_reg[i] <= '0;
                ring_ok_reg[i]    <= 1'b1;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                wake_reg <= wake_next;
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
            // Commit window and keyboard state as the request moves to the result.
            if (advance)
            begin
                slot_reg <= slot_next;
                kb_reg   <= kb_next;
                for (int i = 0; i < WINDOW_DEPTH; i++)
                begin
                    ring_angle_reg[i] <= ring_angle_next[i];
                    ring_ok_reg[i]    <= ring_ok_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            in_reg <= sample;
        if (advance)
            out_reg <= out_next;
    end

endmodule

>>> src/lapg_checker.sv
// ----------------------------------------------------------------------------
// Lid angle peripheral gate checker
// Port-level checks on result codes, stalls and keyboard enable, bound to the gate.
// ----------------------------------------------------------------------------
`include "lid_angle_peripheral_gate_defines.svh"

module lapg_checker
    import lapg_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                sample_ready,
    input logic                result_valid,
    input logic                result_ready,
    input result_t             result
);

    `LAPG_ASSERT_NOW(a_decision_code, result_valid, result.decision <= REQ_DISABLE)
    `LAPG_ASSERT_NOW(a_enable_sets_kb, result_valid && result.decision == REQ_ENABLE, result.keyboard_on)
    `LAPG_ASSERT_NOW(a_stall_source, !sample_ready, result_valid && !result_ready)
    `LAPG_ASSERT_NEXT(a_result_holds, result_valid && !result_ready, result_valid && $stable(result))

endmodule

bind lid_angle_peripheral_gate lapg_checker u_lapg_checker (.*);

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lid angle peripheral gate testbench
// Drives angle samples and chipset events through the request channel under
// random idling on both sides, steps a behavioral model of the angle window
// and keyboard gate for each accepted request, and compares every result
// field by field. The wake angle is rewritten between phases, across its
// extremes and past its saturation point.
// ----------------------------------------------------------------------------
module tb_top;
    import lapg_pkg::*;

    localparam int ANGLE_MAX   = 2**ANGLE_W - 1;
    localparam int BAND_ENABLE = 0;
    localparam int BAND_IGNORE = 1;
    localparam int BAND_ANY    = 2;
    localparam int PHASE_ITEMS = 130;
    localparam int NUM_PHASES  = 9;

    logic                clk;
    logic                rst_n        = 1'b0;
    logic                sample_valid = 1'b0;
    logic                sample_ready;
    sample_t             sample       = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    result_t             result;
    logic                cfg_valid    = 1'b0;
    logic                cfg_ready;
    logic [ANGLE_W-1:0]  cfg_data     = '0;

    // Window and keyboard model
    logic [ANGLE_W-1:0]      win_angle [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] win_ok;
    logic [SLOT_W-1:0]       win_slot;
    logic                    kbd_on;
    logic [ANGLE_W-1:0]      wake_deg;

    sample_t sample_backlog [$];
    result_t predicted_results [$];

    logic steady = 1'b0;
    int   mismatches = 0;
    int   results_seen = 0;
    int   enable_seen = 0;
    int   disable_seen = 0;
    int   wake_writes = 0;

    lid_angle_peripheral_gate dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic in_enable_band(logic [ANGLE_W-1:0] a);
        int w;
        w = int'(wake_deg);
        if (w == int'(MIN_LARGE))
            return 1'b0;
        if (w == int'(MAX_LARGE))
            return 1'b1;
        return int'(a) >= int'(ENABLE_LOW) && int'(a) <= w - int'(HYST_DEG);
    endfunction

    function automatic logic in_ignore_band(logic [ANGLE_W-1:0] a);
        int w;
        w = int'(wake_deg);
        if (w == int'(MIN_LARGE))
            return 1'b1;
        if (w == int'(MAX_LARGE))
            return 1'b0;
        return int'(a) <= int'(IGNORE_HIGH) || int'(a) >= w + int'(HYST_DEG);
    endfunction

    // Step the window model by one request and return the result it gives.
    function automatic result_t qualify_sample(sample_t s);
        result_t r;
        logic    all_enable;
        logic    all_ignore;
        logic    raise;
        logic    want_enable;
        int      i;
        raise       = 1'b0;
        want_enable = 1'b0;
        case (s.op)
            OP_ANGLE:
            begin
                win_angle[win_slot] = s.angle;
                win_ok[win_slot]    = s.angle_reliable;
                win_slot = (win_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : win_slot + 1'b1;
                if (&win_ok)
                begin
                    all_enable = 1'b1;
                    all_ignore = 1'b1;
                    for (i = 0; i < WINDOW_DEPTH; i++)
                    begin
                        if (!in_enable_band(win_angle[i]))
                            all_enable = 1'b0;
                        if (!in_ignore_band(win_angle[i]))
                            all_ignore = 1'b0;
                    end
                    // enable wins when every sample sits in both bands
                    raise       = all_enable || all_ignore;
                    want_enable = all_enable;
                end
            end
            OP_RESUME:
            begin
                raise       = 1'b1;
                want_enable = 1'b1;
            end
            OP_SUSPEND:
                raise = TABLET_SUPPORT && s.tablet_active;
            default:
                raise = 1'b0;
        endcase
        r.decision = REQ_NONE;
        if (raise)
        begin
            if (TABLET_SUPPORT && s.tablet_active)
                want_enable = 1'b0;
            if (want_enable)
            begin
                kbd_on     = 1'b1;
                r.decision = REQ_ENABLE;
            end
            else
            begin
                // keyboard stays on while the chipset is up
                if (!s.chipset_on)
                    kbd_on = 1'b0;
                r.decision = REQ_DISABLE;
            end
        end
        r.keyboard_on       = kbd_on;
        r.window_unreliable = ~&win_ok;
        return r;
    endfunction

    function automatic void push_item(op_t op, logic [ANGLE_W-1:0] angle, logic reliable,
                                      logic tablet, logic chip);
        sample_t s;
        s.op             = op;
        s.angle          = angle;
        s.angle_reliable = reliable;
        s.tablet_active  = tablet;
        s.chipset_on     = chip;
        sample_backlog.push_back(s);
    endfunction

    // Pick an angle in or just outside a band for the current wake angle, often at its edge.
    function automatic logic [ANGLE_W-1:0] pick_angle(int band);
        int   w;
        int   hi_en;
        int   lo_ign;
        logic near_pick;
        logic special;
        w         = int'(wake_deg);
        hi_en     = w - int'(HYST_DEG);
        lo_ign    = w + int'(HYST_DEG);
        near_pick = ($urandom_range(9) < 3);
        special   = (w == int'(MIN_LARGE)) || (w == int'(MAX_LARGE));
        if (band == BAND_ENABLE && !special && hi_en >= int'(ENABLE_LOW))
        begin
            if (near_pick)
                return ANGLE_W'($urandom_range(1) ? int'(ENABLE_LOW) : hi_en);
            return ANGLE_W'($urandom_range(hi_en, int'(ENABLE_LOW)));
        end
        if (band == BAND_IGNORE && !special)
        begin
            if ($urandom_range(1))
                return near_pick ? IGNORE_HIGH : ANGLE_W'($urandom_range(int'(IGNORE_HIGH), 0));
            return ANGLE_W'(near_pick ? lo_ign : $urandom_range(ANGLE_MAX, lo_ign));
        end
        // just outside the bands
        if (near_pick && !special)
        begin
            if ($urandom_range(1))
                return ANGLE_W'(w + int'($urandom_range(2)) - 1);
            return ANGLE_W'($urandom_range(int'(ENABLE_LOW) - 1, int'(IGNORE_HIGH) + 1));
        end
        return ANGLE_W'($urandom_range(ANGLE_MAX));
    endfunction

    task automatic queue_random_mix(input int count);
        int   made;
        int   kind;
        int   len;
        int   band;
        int   k;
        logic tab;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(99);
            tab  = ($urandom_range(4) == 0);
            if (kind < 60)
            begin
                // runs of same-band samples so the window fills and decides
                band = $urandom_range(1) ? BAND_ENABLE : BAND_IGNORE;
                len  = $urandom_range(6, 3);
                for (k = 0; k < len; k++)
                    push_item(OP_ANGLE, pick_angle(band), $urandom_range(29) != 0, tab,
                              1'($urandom_range(1)));
                made += len;
            end
            else if (kind < 75)
            begin
                len = $urandom_range(4, 1);
                for (k = 0; k < len; k++)
                    push_item(OP_ANGLE, pick_angle(BAND_ANY), $urandom_range(4) != 0,
                              1'($urandom_range(1)), 1'($urandom_range(1)));
                made += len;
            end
            else if (kind < 93)
            begin
                push_item($urandom_range(1) ? OP_RESUME : OP_SUSPEND,
                          ANGLE_W'($urandom_range(ANGLE_MAX)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
                made++;
            end
            else
            begin
                push_item(OP_RSVD, ANGLE_W'($urandom_range(ANGLE_MAX)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
                made++;
            end
        end
    endtask

    // Check between edges so every update of the edge has settled.
    task automatic wait_idle();
        while (sample_backlog.size() != 0 || sample_valid || predicted_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_wake(input logic [ANGLE_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        wake_deg = (int'(value) > int'(MAX_LARGE)) ? MAX_LARGE : value;
        wake_writes++;
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
        end
        else
        begin
            if (sample_valid && sample_ready)
                predicted_results.push_back(qualify_sample(sample));
            if (!sample_valid || sample_ready)
            begin
                if (sample_backlog.size() != 0 && (steady || $urandom_range(99) >= 19))
                begin
                    sample       <= sample_backlog.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (predicted_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result: decision %0d keyboard %0b unreliable %0b",
                                 $realtime, result.decision, result.keyboard_on,
                                 result.window_unreliable);
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (want.decision == REQ_ENABLE)
                        enable_seen++;
                    if (want.decision == REQ_DISABLE)
                        disable_seen++;
                    if (result.decision !== want.decision || result.keyboard_on !== want.keyboard_on
                        || result.window_unreliable !== want.window_unreliable)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] result %0d: expected decision %0d keyboard %0b ",
                                      "unreliable %0b, got decision %0d keyboard %0b unreliable %0b"},
                                     $realtime, results_seen, want.decision, want.keyboard_on,
                                     want.window_unreliable, result.decision, result.keyboard_on,
                                     result.window_unreliable);
                    end
                end
            end
            result_ready <= steady || ($urandom_range(99) >= 19);
        end
    end

    initial
    begin
        #2_000_000;
        $display("** lid_angle_peripheral_gate: FAILED **");
        $finish;
    end

    initial
    begin
        logic [ANGLE_W-1:0] wake_plan [NUM_PHASES];
        int                 i;
        for (i = 0; i < WINDOW_DEPTH; i++)
            win_angle[i] = '0;
        win_ok   = '1;
        win_slot = '0;
        kbd_on   = 1'b1;
        wake_deg = DEFAULT_LARGE;
        wake_plan = '{9'd0, 9'd360, 9'd511, 9'd1, 9'd17, 9'd359, 9'd90, 9'd250, 9'd0};
        wake_plan[NUM_PHASES-1] = ANGLE_W'($urandom_range(ANGLE_MAX));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // chipset events and tablet forcing
        push_item(OP_RESUME,  9'd0,   1'b1, 1'b0, 1'b0);
        push_item(OP_RESUME,  9'd0,   1'b1, 1'b1, 1'b0);
        push_item(OP_SUSPEND, 9'd0,   1'b1, 1'b0, 1'b1);
        push_item(OP_RESUME,  9'd511, 1'b0, 1'b0, 1'b1);
        push_item(OP_SUSPEND, 9'd0,   1'b1, 1'b1, 1'b1);
        push_item(OP_SUSPEND, 9'd0,   1'b1, 1'b1, 1'b0);
        push_item(OP_RSVD,    9'd511, 1'b0, 1'b1, 1'b1);
        // fill the window into the enable band, then force through tablet mode
        for (i = 0; i < WINDOW_DEPTH; i++)
            push_item(OP_ANGLE, 9'd90, 1'b1, 1'b0, 1'b0);
        push_item(OP_ANGLE, ENABLE_LOW, 1'b1, 1'b1, 1'b1);
        push_item(OP_ANGLE, 9'd178, 1'b1, 1'b0, 1'b0);
        // unreliable sample, then flush it out with ignore-band angles
        push_item(OP_ANGLE, 9'd0,   1'b0, 1'b0, 1'b0);
        push_item(OP_ANGLE, 9'd511, 1'b1, 1'b0, 1'b0);
        push_item(OP_ANGLE, IGNORE_HIGH, 1'b1, 1'b0, 1'b0);
        push_item(OP_ANGLE, 9'd182, 1'b1, 1'b0, 1'b0);
        push_item(OP_ANGLE, 9'd360, 1'b1, 1'b0, 1'b0);
        // just outside both bands
        push_item(OP_ANGLE, 9'd12,  1'b1, 1'b0, 1'b0);
        push_item(OP_ANGLE, 9'd179, 1'b1, 1'b0, 1'b0);
        push_item(OP_ANGLE, 9'd14,  1'b1, 1'b0, 1'b0);
        push_item(OP_ANGLE, 9'd181, 1'b1, 1'b0, 1'b0);
        wait_idle();

        for (i = 0; i < NUM_PHASES; i++)
        begin
            write_wake(wake_plan[i]);
            steady = (i == 6);
            queue_random_mix(PHASE_ITEMS);
            wait_idle();
            steady = 1'b0;
        end
        repeat (8) @(posedge clk);

        $display("Checked %0d results: %0d enable and %0d disable requests seen.",
                 results_seen, enable_seen, disable_seen);
        $display("Wake angle rewritten %0d times, from 0 through 360 and past saturation.",
                 wake_writes);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("** lid_angle_peripheral_gate: PASSED **");
        else
            $display("** lid_angle_peripheral_gate: FAILED **");
        $finish;
    end

endmodule
